>>> rtl/msde_pkg.sv
// Package for the MIPS subset decode/execute core: word types, kind codes,
// opcode and function codes. No dependencies.
package msde_pkg;

  localparam int unsigned XLEN = 32;

  // result kinds
  localparam logic [3:0] KIND_REG    = 4'd0;
  localparam logic [3:0] KIND_LOAD   = 4'd1;
  localparam logic [3:0] KIND_STORE  = 4'd2;
  localparam logic [3:0] KIND_BRANCH = 4'd3;
  localparam logic [3:0] KIND_JUMP   = 4'd4;
  localparam logic [3:0] KIND_BREAK  = 4'd5;
  localparam logic [3:0] KIND_NOP    = 4'd6;
  localparam logic [3:0] KIND_UNK    = 4'd7;
  localparam logic [3:0] KIND_DATA   = 4'd8;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_BREAK = 6'd13;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_NOR   = 6'd39;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  // REGIMM rt codes
  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  localparam logic [XLEN-1:0] WORD_STEP = 32'd4;

  typedef struct packed {
    logic [XLEN-1:0] instr_word;
    logic [XLEN-1:0] rs_value;
    logic [XLEN-1:0] rt_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]      kind;
    logic [4:0]      dest_reg;
    logic [XLEN-1:0] write_value;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] store_data;
    logic            branch_taken;
    logic [XLEN-1:0] target;
    logic [XLEN-1:0] word_address;
  } out_item_t;

  // per-word sequencing tag: address and mode at the time the word came in
  typedef struct packed {
    logic [XLEN-1:0] word_address;
    logic            data_mode;
  } seq_tag_t;

endpackage

>>> rtl/mips_subset_decode_execute_core.sv
// Top level of the MIPS subset decode/execute core: input register, sequencer,
// execute logic and result register. Depends on msde_pkg, msde_seq, msde_exec.
//
// One word in, one result out, at one word per cycle sustained while
// out_stall is low. An accepted word sits in the input register while the
// execute logic (one 32-bit add/compare plus selection) works on it, then
// moves into the result register once that is free; out_valid rises when
// it lands there, and the result is taken at an edge with out_stall low.
// The result register decouples the sides: a new word is taken while a
// finished result waits, and in_stall rises only when both registers hold
// words and out_stall is high. Each word gets its address from a counter
// that starts at base_address and steps by 4; once a BREAK has gone through
// in the text segment, all later words come back as data words. A write on
// the cfg channel (always ready) loads base_address into the counter and
// leaves the data-mode flag alone; write it only while the core is idle.
module mips_subset_decode_execute_core
  import msde_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_word,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [XLEN-1:0] cfg_data
);

  // input stage
  logic      s1_valid;
  in_item_t  s1_item;
  seq_tag_t  s1_tag;
  // result stage
  logic      s2_valid;
  out_item_t s2_item;

  seq_tag_t  tag;
  out_item_t exec_res;
  logic      in_accept, s2_free, s1_move;

  // result register frees when empty or being taken
  assign s2_free   = !s2_valid || !out_stall;
  assign s1_move   = s1_valid && s2_free;
  assign in_stall  = s1_valid && !s2_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  msde_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .instr_word (in_word.instr_word),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .tag        (tag)
  );

  msde_exec u_exec (
    .item (s1_item),
    .tag  (s1_tag),
    .res  (exec_res)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (!out_stall) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_word;
      s1_tag  <= tag;
    end
    if (s1_move) begin
      s2_item <= exec_res;
    end
  end

  assign out_valid = s2_valid;
  assign out_word  = s2_item;

endmodule

>>> rtl/msde_seq.sv
// Word sequencer: word address counter and text/data mode flag.
// Depends on msde_pkg.
module msde_seq
  import msde_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [XLEN-1:0] instr_word,
  input  logic            cfg_we,
  input  logic [XLEN-1:0] cfg_data,
  output seq_tag_t        tag
);

  logic [XLEN-1:0] word_counter;
  logic            data_mode;
  logic            is_break;

  // BREAK only counts while still in the text segment
  assign is_break = !data_mode && (instr_word[31:26] == OP_SPECIAL)
                    && (instr_word[5:0] == FN_BREAK);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter <= '0;
      data_mode    <= 1'b0;
    end else if (cfg_we) begin
      word_counter <= cfg_data;
    end else if (accept) begin
      word_counter <= word_counter + WORD_STEP;
      if (is_break) begin
        data_mode <= 1'b1;
      end
    end
  end

  assign tag.word_address = word_counter;
  assign tag.data_mode    = data_mode;

endmodule

>>> rtl/msde_exec.sv
// Combinational decode and execute of one word of the MIPS subset.
// Depends on msde_pkg.
module msde_exec
  import msde_pkg::*;
(
  input  in_item_t  item,
  input  seq_tag_t  tag,
  output out_item_t res
);

  logic [XLEN-1:0] w, a, b, imm;
  logic [5:0]      op, fn;
  logic [4:0]      rtf, rdf, sa;

  assign w   = item.instr_word;
  assign a   = item.rs_value;
  assign b   = item.rt_value;
  assign op  = w[31:26];
  assign rtf = w[20:16];
  assign rdf = w[15:11];
  assign sa  = w[10:6];
  assign fn  = w[5:0];
  assign imm = {{16{w[15]}}, w[15:0]};

  always_comb begin
    res              = '0;
    res.kind         = KIND_UNK;
    res.word_address = tag.word_address;
    if (tag.data_mode) begin
      res.kind        = KIND_DATA;
      res.write_value = w;
    end else begin
      unique case (op)
        OP_SPECIAL: begin
          res.kind     = KIND_REG;
          res.dest_reg = rdf;
          unique case (fn)
            FN_SLL: begin
              if (w == '0) begin
                res.kind     = KIND_NOP;
                res.dest_reg = '0;
              end else begin
                res.write_value = b << sa;
              end
            end
            FN_SRL:          res.write_value = b >> sa;
            FN_SRA:          res.write_value = XLEN'($signed(b) >>> sa);
            FN_ADD, FN_ADDU: res.write_value = a + b;
            FN_SUB, FN_SUBU: res.write_value = a - b;
            FN_AND:          res.write_value = a & b;
            FN_OR:           res.write_value = a | b;
            FN_XOR:          res.write_value = a ^ b;
            FN_NOR:          res.write_value = ~(a | b);
            FN_SLT:  res.write_value = {31'd0, ($signed(a) < $signed(b))};
            FN_SLTU: res.write_value = {31'd0, (a < b)};
            FN_BREAK: begin
              res.kind     = KIND_BREAK;
              res.dest_reg = '0;
            end
            default: begin
              res.kind     = KIND_UNK;
              res.dest_reg = '0;
            end
          endcase
        end
        OP_REGIMM: begin
          if (rtf == RT_BGEZ || rtf == RT_BLTZ) begin
            res.kind         = KIND_BRANCH;
            res.target       = {imm[29:0], 2'b00};
            res.branch_taken = (rtf == RT_BGEZ) ? !a[31] : a[31];
          end
        end
        OP_J: begin
          res.kind         = KIND_JUMP;
          res.branch_taken = 1'b1;
          res.target       = {4'd0, w[25:0], 2'b00};
        end
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          res.kind   = KIND_BRANCH;
          res.target = {imm[29:0], 2'b00};
          unique case (op)
            OP_BEQ:  res.branch_taken = (a == b);
            OP_BNE:  res.branch_taken = (a != b);
            OP_BLEZ: res.branch_taken = a[31] || (a == '0);
            default: res.branch_taken = !a[31] && (a != '0);
          endcase
        end
        OP_ADDI, OP_ADDIU: begin
          res.kind        = KIND_REG;
          res.dest_reg    = rtf;
          res.write_value = a + imm;
        end
        OP_SLTI: begin
          res.kind        = KIND_REG;
          res.dest_reg    = rtf;
          res.write_value = {31'd0, ($signed(a) < $signed(imm))};
        end
        OP_LW: begin
          res.kind        = KIND_LOAD;
          res.dest_reg    = rtf;
          res.mem_address = a + imm;
        end
        OP_SW: begin
          res.kind        = KIND_STORE;
          res.mem_address = a + imm;
          res.store_data  = b;
        end
        default: res.kind = KIND_UNK;
      endcase
    end
  end

endmodule

>>> dv/tb_mips_subset_decode_execute_core.sv
// Testbench for mips_subset_decode_execute_core: directed and random word streams,
// checked against an in-bench decode/execute predictor with its own word counter.
// Depends on msde_pkg and the core RTL only.
module tb_mips_subset_decode_execute_core;
  import msde_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_word;
  logic            out_valid;
  logic            out_stall;
  out_item_t       out_word;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [XLEN-1:0] cfg_data;

  mips_subset_decode_execute_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12-unit clock, low half first
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: word counter and data flag
  // ---------------------------------------------------------------------------
  logic [XLEN-1:0] addr_shadow = '0;
  logic            data_shadow = 1'b0;

  // decoded words waiting for the core to hand them back, oldest first
  out_item_t decoded_q [$];

  int  mismatch_count = 0;
  bit  gaps_on  = 1'b1;   // sender inserts idle cycles
  bit  stall_en = 1'b1;   // receiver applies back-pressure

  // ---------------------------------------------------------------------------
  // Decode/execute predictor. Advances the shadow counter and, on BREAK in the
  // text segment, latches data mode for every later word.
  // ---------------------------------------------------------------------------
  function automatic out_item_t execute_word(input in_item_t item);
    out_item_t       r;
    logic [XLEN-1:0] w, a, b, imm;
    logic [5:0]      op, fn;
    logic [4:0]      rtf, rdf, sa;
    w   = item.instr_word;
    a   = item.rs_value;
    b   = item.rt_value;
    op  = w[31:26];
    rtf = w[20:16];
    rdf = w[15:11];
    sa  = w[10:6];
    fn  = w[5:0];
    imm = {{16{w[15]}}, w[15:0]};

    r = '0;
    r.kind = KIND_UNK;
    r.word_address = addr_shadow;
    addr_shadow = addr_shadow + WORD_STEP;

    if (data_shadow) begin
      r.kind = KIND_DATA;
      r.write_value = w;
    end else if (op == OP_SPECIAL) begin
      r.kind = KIND_REG;
      r.dest_reg = rdf;
      case (fn)
        FN_SLL: begin
          // only the all-zero word is a nop; any other SLL writes rd
          if (w == '0) begin
            r.kind = KIND_NOP;
            r.dest_reg = '0;
          end else begin
            r.write_value = b << sa;
          end
        end
        FN_SRL:           r.write_value = b >> sa;
        FN_SRA:           r.write_value = $signed(b) >>> sa;
        FN_ADD, FN_ADDU:  r.write_value = a + b;
        FN_SUB, FN_SUBU:  r.write_value = a - b;
        FN_AND:           r.write_value = a & b;
        FN_OR:            r.write_value = a | b;
        FN_XOR:           r.write_value = a ^ b;
        FN_NOR:           r.write_value = ~(a | b);
        FN_SLT:           r.write_value = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU:          r.write_value = {31'd0, a < b};
        FN_BREAK: begin
          r.kind = KIND_BREAK;
          r.dest_reg = '0;
          data_shadow = 1'b1;
        end
        default: begin
          r.kind = KIND_UNK;
          r.dest_reg = '0;
        end
      endcase
    end else if (op == OP_REGIMM) begin
      // only BLTZ/BGEZ are decoded; other rt codes stay unknown
      if (rtf == RT_BLTZ || rtf == RT_BGEZ) begin
        r.kind = KIND_BRANCH;
        r.target = imm << 2;
        r.branch_taken = (rtf == RT_BGEZ) ? !a[31] : a[31];
      end
    end else begin
      case (op)
        OP_J: begin
          r.kind = KIND_JUMP;
          r.branch_taken = 1'b1;
          r.target = {4'd0, w[25:0], 2'b00};
        end
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          r.kind = KIND_BRANCH;
          r.target = imm << 2;
          case (op)
            OP_BEQ:  r.branch_taken = (a == b);
            OP_BNE:  r.branch_taken = (a != b);
            OP_BLEZ: r.branch_taken = a[31] || (a == '0);
            default: r.branch_taken = !a[31] && (a != '0);
          endcase
        end
        OP_ADDI, OP_ADDIU: begin
          r.kind = KIND_REG;
          r.dest_reg = rtf;
          r.write_value = a + imm;
        end
        OP_SLTI: begin
          r.kind = KIND_REG;
          r.dest_reg = rtf;
          r.write_value = {31'd0, $signed(a) < $signed(imm)};
        end
        OP_LW: begin
          // loaded value unknown here, write_value stays 0
          r.kind = KIND_LOAD;
          r.dest_reg = rtf;
          r.mem_address = a + imm;
        end
        OP_SW: begin
          r.kind = KIND_STORE;
          r.mem_address = a + imm;
          r.store_data = b;
        end
        default: r.kind = KIND_UNK;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Encoders and random pickers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, sa,
                                        input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                        input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // length pick: mostly 1-2, sometimes 3-6, rarely 10-40
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  // operand values biased toward the sign/carry corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_opcode();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return OP_SPECIAL;
      4:          return OP_REGIMM;
      5:          return OP_J;
      6:          return OP_BEQ;
      7:          return OP_BNE;
      8:          return OP_BLEZ;
      9:          return OP_BGTZ;
      10:         return OP_ADDI;
      11:         return OP_ADDIU;
      12:         return OP_SLTI;
      13:         return OP_LW;
      14:         return OP_SW;
      default:    return 6'($urandom);   // anything, unknown opcodes included
    endcase
  endfunction

  function automatic logic [5:0] pick_funct();
    case ($urandom_range(0, 14))
      0:       return FN_SLL;
      1:       return FN_SRL;
      2:       return FN_SRA;
      3:       return FN_ADD;
      4:       return FN_ADDU;
      5:       return FN_SUB;
      6:       return FN_SUBU;
      7:       return FN_AND;
      8:       return FN_OR;
      9:       return FN_XOR;
      10:      return FN_NOR;
      11:      return FN_SLT;
      12:      return FN_SLTU;
      default: return 6'($urandom);
    endcase
  endfunction

  // Random text word: well-formed instruction with random fields, some noise.
  // BREAK is held back so data mode only starts in the last test.
  function automatic logic [31:0] pick_text_word();
    logic [31:0] w;
    int          r;
    r = $urandom_range(0, 99);
    w = $urandom;
    if (r < 2) begin
      w = '0;
    end else if (r >= 12) begin
      w[31:26] = pick_opcode();
      if (w[31:26] == OP_SPECIAL) w[5:0] = pick_funct();
      if (w[31:26] == OP_REGIMM && $urandom_range(0, 3) != 0)
        w[20:16] = $urandom_range(0, 1) ? RT_BGEZ : RT_BLTZ;
    end
    if (w[31:26] == OP_SPECIAL && w[5:0] == FN_BREAK) w[0] = 1'b0;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got, want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // sampled at the rising edge: a result word moves when valid && !stall
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result word with none pending, word_address",
                        out_word.word_address, '0);
      end else begin
        want = decoded_q.pop_front();
        check_field("kind",         32'(out_word.kind),         32'(want.kind));
        check_field("dest_reg",     32'(out_word.dest_reg),     32'(want.dest_reg));
        check_field("write_value",  out_word.write_value,       want.write_value);
        check_field("mem_address",  out_word.mem_address,       want.mem_address);
        check_field("store_data",   out_word.store_data,        want.store_data);
        check_field("branch_taken", 32'(out_word.branch_taken), 32'(want.branch_taken));
        check_field("target",       out_word.target,            want.target);
        check_field("word_address", out_word.word_address,      want.word_address);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: alternating run/stall stretches of random length
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stalling   = 1'b0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stalling = !stalling;
      stall_left = stalling ? pick_len() : 2 * pick_len();
    end
    stall_left--;
    out_stall <= stall_en && stalling;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Drives one word at a falling edge (after an optional idle gap) and waits
  // for the rising edge that accepts it. Valid stays high on return so a
  // following word goes out back to back.
  task automatic send_word(input logic [31:0] w, a, b);
    int       gap;
    in_item_t item;
    item.instr_word = w;
    item.rs_value   = a;
    item.rt_value   = b;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decoded_q.push_back(execute_word(item));
  endtask

  // Drops valid, waits until every pending word has come back, then lets
  // the two-stage pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Base register write; only issued with the core idle. Reloads the counter,
  // data mode untouched.
  task automatic write_base(input logic [31:0] base);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    addr_shadow = base;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // R-type and immediate ALU ops at the wrap and sign corners
  task automatic test_alu_words();
    send_word(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD),    32'h7FFF_FFFF, 32'h0000_0001);
    send_word(enc_r(5'd4, 5'd5, 5'd31, 5'd0, FN_ADDU),  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_SUB),    32'h0000_0000, 32'h0000_0001);
    send_word(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_SUBU),   32'h8000_0000, 32'h0000_0001);
    send_word(enc_r(5'd6, 5'd7, 5'd8, 5'd0, FN_AND),    32'hFFFF_0000, 32'h0F0F_0F0F);
    send_word(enc_r(5'd6, 5'd7, 5'd8, 5'd0, FN_OR),     32'hFFFF_0000, 32'h0F0F_0F0F);
    send_word(enc_r(5'd6, 5'd7, 5'd8, 5'd0, FN_XOR),    32'hFFFF_0000, 32'h0F0F_0F0F);
    send_word(enc_r(5'd0, 5'd0, 5'd9, 5'd0, FN_NOR),    32'h0000_0000, 32'h0000_0000);
    send_word(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_SLT),    32'h8000_0000, 32'h0000_0001);
    send_word(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_SLTU),   32'h8000_0000, 32'h0000_0001);
    // SLL with a nonzero word is a real shift, not a nop
    send_word(enc_r(5'd0, 5'd2, 5'd3, 5'd31, FN_SLL),   32'h0000_0000, 32'h0000_0001);
    send_word(enc_r(5'd0, 5'd2, 5'd3, 5'd31, FN_SRL),   32'h0000_0000, 32'h8000_0000);
    send_word(enc_r(5'd0, 5'd2, 5'd3, 5'd31, FN_SRA),   32'h0000_0000, 32'h8000_0000);
    send_word(enc_i(OP_ADDI, 5'd1, 5'd2, 16'h8000),     32'h0000_0000, 32'h0000_0000);
    send_word(enc_i(OP_ADDIU, 5'd1, 5'd31, 16'h7FFF),   32'hFFFF_FFFF, 32'h0000_0000);
    send_word(enc_i(OP_SLTI, 5'd1, 5'd2, 16'h0000),     32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_load_store();
    send_word(enc_i(OP_LW, 5'd3, 5'd31, 16'hFFFF),  32'h0000_0000, 32'h1234_5678);
    send_word(enc_i(OP_SW, 5'd3, 5'd4, 16'h7FFF),   32'hFFFF_FFFF, 32'hA5A5_5A5A);
  endtask

  task automatic test_branch_jump();
    send_word(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h8000),  32'h5555_5555, 32'h5555_5555);
    send_word(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF),  32'h5555_5555, 32'h5555_5555);
    send_word(enc_i(OP_BLEZ, 5'd1, 5'd0, 16'h0001), 32'h0000_0000, 32'h0000_0000);
    send_word(enc_i(OP_BGTZ, 5'd1, 5'd0, 16'hFFFF), 32'h8000_0000, 32'h0000_0000);
    send_word(enc_i(OP_REGIMM, 5'd1, RT_BLTZ, 16'h0004), 32'h8000_0000, 32'h0);
    send_word(enc_i(OP_REGIMM, 5'd1, RT_BGEZ, 16'hFFFC), 32'h0000_0000, 32'h0);
    send_word({OP_J, 26'h3FF_FFFF},                 32'h0000_0000, 32'h0000_0000);
  endtask

  // all-zero nop, REGIMM with an undecoded rt, unknown opcode and function
  task automatic test_odd_words();
    send_word(32'h0000_0000,                        32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(enc_i(OP_REGIMM, 5'd1, 5'd2, 16'h0010), 32'h8000_0000, 32'h0);
    send_word({6'd63, 26'h3FF_FFFF},                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(enc_r(5'd31, 5'd31, 5'd31, 5'd31, 6'd63), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // counter reload from both ends of the address range, wrap past 2^32
  task automatic test_base_address();
    write_base(32'hFFFF_FFFF);
    send_word(pick_text_word(), $urandom, $urandom);
    send_word(pick_text_word(), $urandom, $urandom);
    write_base(32'h0000_0000);
    send_word(pick_text_word(), $urandom, $urandom);
  endtask

  // Random program in six phases, each with its own base, with sender gaps
  // and receiver stalls set per phase; two phases run back to back with no sender gaps.
  task automatic test_random_program();
    logic [31:0] w, a, b, base;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       base = 32'h0040_0000;
        1:       base = $urandom;
        2:       base = 32'hFFFF_FFF0;
        3:       base = 32'hFFFF_FFFF;
        4:       base = 32'h0000_0000;
        default: base = $urandom & 32'hFFFF_FFFC;
      endcase
      write_base(base);
      gaps_on  = (phase != 1 && phase != 3);
      stall_en = (phase != 1 && phase != 4);
      for (int n = 0; n < 200; n++) begin
        w = pick_text_word();
        a = pick_operand();
        b = pick_operand();
        // equal operands often, so BEQ/BNE take both ways
        if ($urandom_range(0, 9) < 3) b = a;
        send_word(w, a, b);
      end
    end
    gaps_on  = 1'b1;
    stall_en = 1'b1;
  endtask

  // BREAK switches to data mode for good; a base write afterwards reloads
  // the counter but data mode stays. Runs last since only reset clears it.
  task automatic test_break_then_data();
    logic [31:0] w;
    send_word(enc_r(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), FN_BREAK),
              $urandom, $urandom);
    for (int pass = 0; pass < 2; pass++) begin
      for (int n = 0; n < 30; n++) begin
        case (n % 10)
          0:       w = '0;
          5:       w = enc_r(5'd1, 5'd2, 5'd3, 5'd4, FN_BREAK);
          default: w = $urandom;
        endcase
        send_word(w, $urandom, $urandom);
      end
      if (pass == 0) write_base(32'hFFFF_FFFC);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_alu_words();
    test_load_store();
    test_branch_jump();
    test_odd_words();
    test_base_address();
    test_random_program();
    test_break_then_data();

    drain_results();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(12 * 1000000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
